// File: design/lirs_pkg.sv
// shared constants and codes for the linear interpolating resampler
package lirs_pkg;

  localparam int FETCH_BITS = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int STEP_INT_BITS = 4;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_SOURCE = 1'b1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_HIGH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER_LOW = 2'd2;

endpackage

// File: design/lirs_cfg.sv
// configuration registers: phase step and trigger thresholds
module lirs_cfg #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS = 16,
  parameter int STEP_BITS = 20,
  parameter int CFG_BITS = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [lirs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  output logic [STEP_BITS-1:0]                phase_step,
  output logic signed [SAMPLE_BITS-1:0]       trigger_high,
  output logic signed [SAMPLE_BITS-1:0]       trigger_low
);
  import lirs_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_BITS'(1) << FRAC_BITS;
      trigger_high <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
      trigger_low <= SAMPLE_BITS'(1) << (SAMPLE_BITS - 3);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_PHASE_STEP: phase_step <= cfg_data[STEP_BITS-1:0];
        CFG_TRIGGER_HIGH: trigger_high <= cfg_data[SAMPLE_BITS-1:0];
        CFG_TRIGGER_LOW: trigger_low <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/lirs_interp.sv
// sample history, phase accumulator and linear interpolation
module lirs_interp #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS = 16,
  parameter int STEP_BITS = 20
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic                            func,
  input  logic signed [SAMPLE_BITS-1:0]   source_sample,
  input  logic [STEP_BITS-1:0]            phase_step,
  output logic signed [SAMPLE_BITS-1:0]   out_sample_next,
  output logic [lirs_pkg::FETCH_BITS-1:0] fetch_count_next
);
  import lirs_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int SUM_BITS = FRAC_BITS + FETCH_BITS;

  logic signed [SAMPLE_BITS-1:0] older_sample;
  logic signed [SAMPLE_BITS-1:0] newer_sample;
  logic [FRAC_BITS-1:0]          phase_fraction;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [FRAC_BITS:0]     weight;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   base;
  logic signed [PROD_BITS-1:0]   weighted;
  logic signed [PROD_BITS-1:0]   biased;
  logic signed [PROD_BITS-1:0]   quot;
  logic [SUM_BITS-1:0]           sum;

  // older*(1-p) + newer*p rewritten as older + (newer-older)*p
  assign diff = {newer_sample[SAMPLE_BITS-1], newer_sample}
                - {older_sample[SAMPLE_BITS-1], older_sample};
  assign weight = {1'b0, phase_fraction};
  assign prod = PROD_BITS'(diff) * PROD_BITS'(weight);
  assign base = PROD_BITS'(older_sample) <<< FRAC_BITS;
  assign weighted = base + prod;
  // round toward zero for negative sums
  assign biased = weighted[PROD_BITS-1] ?
                  weighted + PROD_BITS'((PROD_BITS'(1) << FRAC_BITS) - PROD_BITS'(1)) :
                  weighted;
  assign quot = biased >>> FRAC_BITS;
  assign out_sample_next = quot[SAMPLE_BITS-1:0];

  assign sum = SUM_BITS'(phase_fraction) + SUM_BITS'(phase_step);
  assign fetch_count_next = sum[SUM_BITS-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample <= '0;
      newer_sample <= '0;
      phase_fraction <= '0;
    end else if (step) begin
      if (func == FUNC_SOURCE) begin
        older_sample <= newer_sample;
        newer_sample <= source_sample;
      end else begin
        phase_fraction <= sum[FRAC_BITS-1:0];
      end
    end
  end

endmodule

// File: design/lirs_trig.sv
// hysteresis trigger on the control sample of each tick
module lirs_trig #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          func,
  input  logic signed [SAMPLE_BITS-1:0] control_sample,
  input  logic signed [SAMPLE_BITS-1:0] trigger_high,
  input  logic signed [SAMPLE_BITS-1:0] trigger_low,
  output logic                          trigger_event_next
);
  import lirs_pkg::*;

  logic trigger_armed_off;
  logic rearm;

  assign trigger_event_next = (control_sample > trigger_high) && !trigger_armed_off;
  assign rearm = (control_sample < trigger_low) && trigger_armed_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_armed_off <= 1'b0;
    end else if (step && func == FUNC_TICK) begin
      if (trigger_event_next) begin
        trigger_armed_off <= 1'b1;
      end else if (rearm) begin
        trigger_armed_off <= 1'b0;
      end
    end
  end

endmodule

// File: design/linear_interp_resampler_with_trigger.sv
// top level of the linear interpolating resampler with trigger
//
// Requests enter on in_valid/in_ready. func = 1 delivers a source sample
// into the two-sample history and produces no result. func = 0 is a tick:
// it produces one result on out_valid/out_ready with the interpolated
// sample, the number of source samples to deliver before the next tick
// (carry of phase plus phase_step), and a one-shot hysteresis trigger flag.
// A request is captured in an input register, evaluated by the
// interpolator multiply and phase adder, and a tick's result lands in
// the output register. One request is accepted every cycle except
// while in_ready is low, which happens only when the receiver stalls.
// When the receiver stalls, a result waits in the output register; source
// requests still pass, and a tick waits in the input register until the
// output register frees, so in_ready drops only while both are full.
// Reset clears history, phase and trigger state and loads the register
// defaults: phase step 1.0, high threshold 2^(SAMPLE_BITS-2), low
// threshold 2^(SAMPLE_BITS-3). Registers are written on cfg_wen.
module linear_interp_resampler_with_trigger #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS = 16,
  localparam int STEP_BITS = FRAC_BITS + lirs_pkg::STEP_INT_BITS,
  localparam int CFG_BITS = (STEP_BITS > SAMPLE_BITS) ? STEP_BITS : SAMPLE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [lirs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                 cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                func,
  input  logic signed [SAMPLE_BITS-1:0]       control_sample,
  input  logic signed [SAMPLE_BITS-1:0]       source_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic [lirs_pkg::FETCH_BITS-1:0]     fetch_count,
  output logic                                trigger_event
);
  import lirs_pkg::*;

  logic [STEP_BITS-1:0]          phase_step;
  logic signed [SAMPLE_BITS-1:0] trigger_high;
  logic signed [SAMPLE_BITS-1:0] trigger_low;

  logic                          hold_valid;
  logic                          hold_func;
  logic signed [SAMPLE_BITS-1:0] hold_control;
  logic signed [SAMPLE_BITS-1:0] hold_source;

  logic                          advance;
  logic signed [SAMPLE_BITS-1:0] out_sample_next;
  logic [FETCH_BITS-1:0]         fetch_count_next;
  logic                          trigger_event_next;

  assign advance = hold_valid && (hold_func == FUNC_SOURCE || !out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  lirs_cfg #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS),
    .STEP_BITS(STEP_BITS),
    .CFG_BITS(CFG_BITS)
  ) u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .phase_step(phase_step),
    .trigger_high(trigger_high),
    .trigger_low(trigger_low)
  );

  lirs_interp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS),
    .STEP_BITS(STEP_BITS)
  ) u_interp (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .func(hold_func),
    .source_sample(hold_source),
    .phase_step(phase_step),
    .out_sample_next(out_sample_next),
    .fetch_count_next(fetch_count_next)
  );

  lirs_trig #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_trig (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .func(hold_func),
    .control_sample(hold_control),
    .trigger_high(trigger_high),
    .trigger_low(trigger_low),
    .trigger_event_next(trigger_event_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_func <= func;
      hold_control <= control_sample;
      hold_source <= source_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold_func == FUNC_TICK) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold_func == FUNC_TICK) begin
      out_sample <= out_sample_next;
      fetch_count <= fetch_count_next;
      trigger_event <= trigger_event_next;
    end
  end

endmodule
